// ----- design/qjwd_pkg.sv -----
// shared types, constants and helper functions of the jog wheel decoder
package qjwd_pkg;

    localparam int unsigned NUM_AXES_DEF = 3;
    localparam int unsigned AXIS_W       = 2;
    localparam int unsigned COUNT_W      = 32;
    localparam int unsigned RATE_W       = 4;
    localparam int unsigned CMD_W        = 3;
    localparam int unsigned HIST_W       = 8;
    localparam int unsigned PADDR_W      = 3;
    localparam int unsigned PDATA_W      = 32;

    localparam logic [RATE_W-1:0] JOG_RATE_MAX_RST = 4'd3;

    // register index, taken from the word address bit
    localparam logic REG_JOG_RATE_MAX = 1'b0;

    // legal 4-bit transitions {prev b, prev a, b, a}
    localparam logic [15:0] VALID_CODE = 16'b0110_1001_1001_0110;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE      = 3'd0,
        CMD_AXIS_TOGGLE = 3'd1,
        CMD_RATE_STEP   = 3'd2,
        CMD_CLEAR       = 3'd3,
        CMD_SELECT      = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              pin_a;
        logic              pin_b;
        logic [AXIS_W-1:0] axis_index;
    } t_item;

    typedef struct packed {
        logic [AXIS_W-1:0]         active_axis;
        logic signed [COUNT_W-1:0] wheel_count;
        logic signed [COUNT_W-1:0] pos_x;
        logic signed [COUNT_W-1:0] pos_y;
        logic signed [COUNT_W-1:0] pos_z;
        logic                      position_changed;
        logic                      valid_transition;
        logic [RATE_W-1:0]         jog_rate;
    } t_result;

    function automatic logic is_count_down(input logic [HIST_W-1:0] h);
        return (h == 8'h42) || (h == 8'hD4) || (h == 8'h2B) || (h == 8'hBD);
    endfunction

    function automatic logic is_count_up(input logic [HIST_W-1:0] h);
        return (h == 8'h81) || (h == 8'h17) || (h == 8'hE8) || (h == 8'h7E);
    endfunction

endpackage

// ----- design/quadrature_jog_wheel_decoder.sv -----
// Hand-wheel quadrature decoder with axis selection and jog-rate stepping.
// Each accepted item gives exactly one result. An item is captured in an input
// register, goes through the state update and lands in the result register, so a
// new item can be taken every cycle while the result is not stalled; the update of
// history, count and axis positions is the loop that sets this rate. A stalled
// result holds the pipeline, while the input register still takes one more item.
// jog_rate_max sits at byte address 0 of the apb-style port (reset value 3).
module quadrature_jog_wheel_decoder #(
    parameter int unsigned NUM_AXES = qjwd_pkg::NUM_AXES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [qjwd_pkg::CMD_W-1:0]         i_cmd,
    input  logic                               i_pin_a,
    input  logic                               i_pin_b,
    input  logic [qjwd_pkg::AXIS_W-1:0]        i_axis_index,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [qjwd_pkg::AXIS_W-1:0]        o_active_axis,
    output logic signed [qjwd_pkg::COUNT_W-1:0] o_wheel_count,
    output logic signed [qjwd_pkg::COUNT_W-1:0] o_pos_x,
    output logic signed [qjwd_pkg::COUNT_W-1:0] o_pos_y,
    output logic signed [qjwd_pkg::COUNT_W-1:0] o_pos_z,
    output logic                               o_position_changed,
    output logic                               o_valid_transition,
    output logic [qjwd_pkg::RATE_W-1:0]        o_jog_rate,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qjwd_pkg::PADDR_W-1:0]       paddr,
    input  logic [qjwd_pkg::PDATA_W-1:0]       pwdata,
    output logic [qjwd_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import qjwd_pkg::*;

    logic              r_s1_valid;
    t_item             r_s1_item;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_result;
    logic              w_out_free;
    logic              w_advance;
    logic              w_in_take;
    logic [RATE_W-1:0] w_jog_rate_max;

    qjwd_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_jog_rate_max (w_jog_rate_max)
    );

    qjwd_core #(
        .NUM_AXES (NUM_AXES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_item         (r_s1_item),
        .i_jog_rate_max (w_jog_rate_max),
        .o_result       (w_result)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_item.cmd        <= i_cmd;
            r_s1_item.pin_a      <= i_pin_a;
            r_s1_item.pin_b      <= i_pin_b;
            r_s1_item.axis_index <= i_axis_index;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_active_axis      = r_out.active_axis;
    assign o_wheel_count      = r_out.wheel_count;
    assign o_pos_x            = r_out.pos_x;
    assign o_pos_y            = r_out.pos_y;
    assign o_pos_z            = r_out.pos_z;
    assign o_position_changed = r_out.position_changed;
    assign o_valid_transition = r_out.valid_transition;
    assign o_jog_rate         = r_out.jog_rate;

endmodule

// ----- design/qjwd_regs.sv -----
// configuration register file behind the apb-style port
module qjwd_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qjwd_pkg::PADDR_W-1:0]   paddr,
    input  logic [qjwd_pkg::PDATA_W-1:0]   pwdata,
    output logic [qjwd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic [qjwd_pkg::RATE_W-1:0]    o_jog_rate_max
);
    import qjwd_pkg::*;

    logic              w_write;
    logic              w_reg_idx;
    logic [RATE_W-1:0] r_jog_rate_max;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1];
    assign w_write   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jog_rate_max <= JOG_RATE_MAX_RST;
        end else if (w_write && (w_reg_idx == REG_JOG_RATE_MAX)) begin
            r_jog_rate_max <= pwdata[RATE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == REG_JOG_RATE_MAX) begin
            prdata[RATE_W-1:0] = r_jog_rate_max;
        end
    end

    assign o_jog_rate_max = r_jog_rate_max;

endmodule

// ----- design/qjwd_core.sv -----
// decoder state and its combinational next-state and result logic
module qjwd_core #(
    parameter int unsigned NUM_AXES = qjwd_pkg::NUM_AXES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  qjwd_pkg::t_item             i_item,
    input  logic [qjwd_pkg::RATE_W-1:0] i_jog_rate_max,
    output qjwd_pkg::t_result           o_result
);
    import qjwd_pkg::*;

    logic [HIST_W-1:0]         r_hist,  n_hist;
    logic [COUNT_W-1:0]        r_count, n_count;
    logic [AXIS_W-1:0]         r_axis,  n_axis;
    logic [RATE_W-1:0]         r_rate,  n_rate;
    logic [COUNT_W-1:0]        r_pos [NUM_AXES];
    logic [COUNT_W-1:0]        n_pos [NUM_AXES];
    logic [COUNT_W-1:0]        w_pos_out [3];

    logic [3:0]                w_code;
    logic [HIST_W-1:0]         w_hist_shift;
    logic                      w_valid;
    logic [COUNT_W-1:0]        w_count_step;
    logic [AXIS_W:0]           w_axis_inc;
    logic [NUM_AXES-1:0]       w_lane_changed;
    logic                      w_sample_ok;
    t_cmd                      w_cmd;

    assign w_cmd        = t_cmd'(i_item.cmd);
    assign w_code       = {r_hist[1:0], i_item.pin_b, i_item.pin_a};
    assign w_hist_shift = {r_hist[3:0], w_code};
    assign w_valid      = VALID_CODE[w_code];
    assign w_sample_ok  = (w_cmd == CMD_SAMPLE) && w_valid;
    assign w_axis_inc   = {1'b0, r_axis} + {{AXIS_W{1'b0}}, 1'b1};

    always_comb begin
        priority if (is_count_down(w_hist_shift)) begin
            w_count_step = r_count - {{(COUNT_W-1){1'b0}}, 1'b1};
        end else if (is_count_up(w_hist_shift)) begin
            w_count_step = r_count + {{(COUNT_W-1){1'b0}}, 1'b1};
        end else begin
            w_count_step = r_count;
        end
    end

    always_comb begin
        n_hist  = r_hist;
        n_count = r_count;
        n_axis  = r_axis;
        n_rate  = r_rate;
        unique case (w_cmd)
            CMD_SAMPLE: begin
                if (w_valid) begin
                    n_hist  = w_hist_shift;
                    n_count = w_count_step;
                end
            end
            CMD_AXIS_TOGGLE: begin
                if (w_axis_inc >= (AXIS_W+1)'(NUM_AXES)) begin
                    n_axis = '0;
                end else begin
                    n_axis = w_axis_inc[AXIS_W-1:0];
                end
            end
            CMD_RATE_STEP: begin
                n_rate = (r_rate == i_jog_rate_max) ? '0 : r_rate + {{(RATE_W-1){1'b0}}, 1'b1};
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_SELECT: begin
                if ({1'b0, i_item.axis_index} < (AXIS_W+1)'(NUM_AXES)) begin
                    n_axis = i_item.axis_index;
                end
            end
            default: begin
            end
        endcase
    end

    // one lane per axis; only the selected lane follows the count on a sample, and a clear zeroes every lane
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        always_comb begin
            n_pos[a]          = r_pos[a];
            w_lane_changed[a] = 1'b0;
            if (w_cmd == CMD_CLEAR) begin
                n_pos[a] = '0;
            end else if (w_sample_ok && (r_axis == AXIS_W'(a))) begin
                if (r_pos[a] != w_count_step) begin
                    n_pos[a]          = w_count_step;
                    w_lane_changed[a] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos[a] <= '0;
            end else if (i_advance) begin
                r_pos[a] <= n_pos[a];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_pos_out
        if (a < NUM_AXES) begin : g_present
            assign w_pos_out[a] = n_pos[a];
        end else begin : g_absent
            assign w_pos_out[a] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_count <= '0;
            r_axis  <= '0;
            r_rate  <= '0;
        end else if (i_advance) begin
            r_hist  <= n_hist;
            r_count <= n_count;
            r_axis  <= n_axis;
            r_rate  <= n_rate;
        end
    end

    always_comb begin
        o_result.active_axis      = n_axis;
        o_result.wheel_count      = n_count;
        o_result.pos_x            = w_pos_out[0];
        o_result.pos_y            = w_pos_out[1];
        o_result.pos_z            = w_pos_out[2];
        o_result.position_changed = |w_lane_changed;
        o_result.valid_transition = w_sample_ok;
        o_result.jog_rate         = n_rate;
    end

endmodule
